/* sv/ddbsp_pkg.sv */
package ddbsp_pkg;

   localparam int MAX_SECTION_BYTES_DEF = 4096;
   localparam int MIN_SIZE_W            = 13;
   localparam int POS_W                 = 18;

   localparam logic [MIN_SIZE_W-1:0] MIN_SIZE_RESET = 13'd12;
   localparam logic [15:0]           DDB_MESSAGE_ID = 16'h1003;
   localparam logic [31:0]           CRC_POLY       = 32'h04C1_1DB7;
   localparam logic [31:0]           CRC_INIT       = 32'hFFFF_FFFF;

   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_SIZE    = 3'd1,
      ST_CRC     = 3'd2,
      ST_LENGTH  = 3'd3,
      ST_NOT_DDB = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] section_byte;
      logic       last_byte;
   } item_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      status_type status;
      logic [15:0] tid_ext;
      logic [4:0]  sect_version;
      logic [7:0]  sect_index;
      logic [7:0]  last_sect_index;
      logic [15:0] message_id;
      logic [31:0] download_id;
      logic [15:0] module_id;
      logic [7:0]  module_version;
      logic [15:0] block_number;
   } result_type;

   typedef struct packed {
      logic        size_overflow;
      logic [31:0] crc;
      logic [11:0] length;
      logic [15:0] ext;
      logic [4:0]  version;
      logic [7:0]  sec_num;
      logic [7:0]  last_sec;
      logic [15:0] msg_id;
      logic [31:0] dl_id;
      logic [7:0]  adapt_len;
      logic [15:0] msg_len;
      logic [15:0] mod_id;
      logic [7:0]  mod_ver;
      logic [15:0] block_num;
   } section_type;

   localparam section_type SECTION_CLEAR = '{
      size_overflow: 1'b0,
      crc:           CRC_INIT,
      length:        12'd0,
      ext:           16'd0,
      version:       5'd0,
      sec_num:       8'd0,
      last_sec:      8'd0,
      msg_id:        16'd0,
      dl_id:         32'd0,
      adapt_len:     8'd0,
      msg_len:       16'd0,
      mod_id:        16'd0,
      mod_ver:       8'd0,
      block_num:     16'd0
   };

   // mpeg-2 crc-32, msb first, one byte
   function automatic logic [31:0] crc8_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {b, 24'h000000};
      for (int i = 0; i < 8; i++) begin
         c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

/* sv/ddbsp_in_reg.sv */
module ddbsp_in_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ddbsp_pkg::item_type req_item,
   input  logic                advance,
   output logic                item_valid,
   output ddbsp_pkg::item_type item
);

   logic                valid_ff;
   ddbsp_pkg::item_type item_ff;

   assign req_stall  = valid_ff & ~advance;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!req_stall) begin
         valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         item_ff <= req_item;
      end
   end

endmodule

/* sv/ddbsp_core.sv */
module ddbsp_core #(
   parameter int MAX_SECTION_BYTES = ddbsp_pkg::MAX_SECTION_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  ddbsp_pkg::item_type                  item,
   input  logic [ddbsp_pkg::MIN_SIZE_W-1:0]     min_size,
   output logic                                 res_valid,
   output ddbsp_pkg::result_type                res
);

   localparam int CW = $clog2(MAX_SECTION_BYTES + 1);
   localparam int LW = ddbsp_pkg::POS_W;

   logic [CW-1:0]          byte_count_ff;
   logic [CW-1:0]          byte_count_in;
   ddbsp_pkg::section_type sec_ff;
   ddbsp_pkg::section_type sec_in;

   logic          counted;
   logic [LW-1:0] pos_w;
   logic [LW-1:0] rel_w;
   logic [LW-1:0] size_w;
   logic [LW-1:0] adapt_w;
   logic [LW-1:0] msg_len_w;
   logic [7:0]    b;
   logic          in_data;

   assign b         = item.section_byte;
   assign counted   = byte_count_ff < CW'(MAX_SECTION_BYTES);
   assign pos_w     = LW'(byte_count_ff);
   assign adapt_w   = LW'(sec_ff.adapt_len);
   assign msg_len_w = LW'(sec_ff.msg_len);
   assign rel_w     = pos_w - (LW'(20) + adapt_w);

   always_comb begin
      sec_in               = sec_ff;
      sec_in.crc           = ddbsp_pkg::crc8_update(sec_ff.crc, b);
      sec_in.size_overflow = sec_ff.size_overflow | ~counted;
      byte_count_in        = counted ? byte_count_ff + CW'(1) : byte_count_ff;
      if (counted) begin
         case (pos_w)
            LW'(1):  sec_in.length   = {b[3:0], 8'h00};
            LW'(2):  sec_in.length   = {sec_ff.length[11:8], b};
            LW'(3), LW'(4):   sec_in.ext      = {sec_ff.ext[7:0], b};
            LW'(5):  sec_in.version  = b[5:1];
            LW'(6):  sec_in.sec_num  = b;
            LW'(7):  sec_in.last_sec = b;
            LW'(10), LW'(11): sec_in.msg_id   = {sec_ff.msg_id[7:0], b};
            LW'(12), LW'(13), LW'(14), LW'(15):
                     sec_in.dl_id    = {sec_ff.dl_id[23:0], b};
            LW'(17): sec_in.adapt_len = b;
            LW'(18), LW'(19): sec_in.msg_len  = {sec_ff.msg_len[7:0], b};
            default: ;
         endcase
         if (pos_w >= LW'(20) + adapt_w) begin
            if (rel_w == LW'(0) || rel_w == LW'(1)) begin
               sec_in.mod_id = {sec_ff.mod_id[7:0], b};
            end else if (rel_w == LW'(2)) begin
               sec_in.mod_ver = b;
            end else if (rel_w == LW'(4) || rel_w == LW'(5)) begin
               sec_in.block_num = {sec_ff.block_num[7:0], b};
            end
         end
      end
   end

   // header fields settle before offset 26, so the stored values hold here
   assign in_data = counted
                  && (sec_ff.msg_id == ddbsp_pkg::DDB_MESSAGE_ID)
                  && (msg_len_w > adapt_w + LW'(6))
                  && (pos_w >= LW'(26) + adapt_w)
                  && (pos_w < LW'(20) + msg_len_w);

   assign size_w = LW'(byte_count_in);

   always_comb begin
      res       = '0;
      res.kind  = ddbsp_pkg::KIND_DATA;
      res.status = ddbsp_pkg::ST_OK;
      res_valid = 1'b0;
      if (!item.last_byte) begin
         if (in_data) begin
            res_valid     = 1'b1;
            res.data_byte = b;
         end
      end else begin
         res_valid = 1'b1;
         res.kind  = ddbsp_pkg::KIND_SUMMARY;
         if (sec_in.size_overflow || size_w < LW'(min_size) || size_w < LW'(4)) begin
            res.status = ddbsp_pkg::ST_SIZE;
         end else if (sec_in.crc != 32'd0) begin
            res.status = ddbsp_pkg::ST_CRC;
         end else if (LW'(sec_in.length) + LW'(3) != size_w) begin
            res.status = ddbsp_pkg::ST_LENGTH;
         end else begin
            res.tid_ext         = sec_in.ext;
            res.sect_version    = sec_in.version;
            res.sect_index      = sec_in.sec_num;
            res.last_sect_index = sec_in.last_sec;
            if (size_w > LW'(12)) begin
               res.message_id  = sec_in.msg_id;
               res.download_id = sec_in.dl_id;
               if (sec_in.msg_len > 16'(sec_in.adapt_len)) begin
                  if (sec_in.msg_id == ddbsp_pkg::DDB_MESSAGE_ID) begin
                     res.module_id      = sec_in.mod_id;
                     res.module_version = sec_in.mod_ver;
                     res.block_number   = sec_in.block_num;
                  end else begin
                     res.status = ddbsp_pkg::ST_NOT_DDB;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
         sec_ff        <= ddbsp_pkg::SECTION_CLEAR;
      end else if (step) begin
         if (item.last_byte) begin
            byte_count_ff <= '0;
            sec_ff        <= ddbsp_pkg::SECTION_CLEAR;
         end else begin
            byte_count_ff <= byte_count_in;
            sec_ff        <= sec_in;
         end
      end
   end

endmodule

/* sv/dsmcc_ddb_section_parser.sv */
// pipeline: the input register takes the item, the result register loads when the item advances
// throughput: one item per cycle unless the receiver stalls, set by the byte-wide crc
// and field capture in the core stage between the input register and the result register
// reset: synchronous, clears the section state (crc to all ones, counts and
// fields to zero), empties both registers and sets min_section_size to 12
module dsmcc_ddb_section_parser #(
   parameter int MAX_SECTION_BYTES = ddbsp_pkg::MAX_SECTION_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_section_byte,
   input  logic        req_last_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_tid_ext,
   output logic [4:0]  rsp_sect_version,
   output logic [7:0]  rsp_sect_index,
   output logic [7:0]  rsp_last_sect_index,
   output logic [15:0] rsp_message_id,
   output logic [31:0] rsp_download_id,
   output logic [15:0] rsp_module_id,
   output logic [7:0]  rsp_module_version,
   output logic [15:0] rsp_block_number,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [ddbsp_pkg::MIN_SIZE_W-1:0] csr_min_section_size
);

   logic [ddbsp_pkg::MIN_SIZE_W-1:0] min_size_ff;
   logic                  rsp_valid_ff;
   ddbsp_pkg::result_type res_ff;

   ddbsp_pkg::item_type   req_item;
   ddbsp_pkg::item_type   item;
   logic                  item_valid;
   logic                  advance;
   logic                  core_valid;
   ddbsp_pkg::result_type core_res;

   assign req_item.section_byte = req_section_byte;
   assign req_item.last_byte    = req_last_byte;

   assign advance   = item_valid & (~rsp_valid_ff | ~rsp_stall);
   assign csr_ready = 1'b1;

   ddbsp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ddbsp_core #(
      .MAX_SECTION_BYTES (MAX_SECTION_BYTES)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .item      (item),
      .min_size  (min_size_ff),
      .res_valid (core_valid),
      .res       (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_size_ff <= ddbsp_pkg::MIN_SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         min_size_ff <= csr_min_section_size;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= core_valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && core_valid) begin
         res_ff <= core_res;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = res_ff.kind;
   assign rsp_data_byte       = res_ff.data_byte;
   assign rsp_status          = res_ff.status;
   assign rsp_tid_ext         = res_ff.tid_ext;
   assign rsp_sect_version    = res_ff.sect_version;
   assign rsp_sect_index      = res_ff.sect_index;
   assign rsp_last_sect_index = res_ff.last_sect_index;
   assign rsp_message_id      = res_ff.message_id;
   assign rsp_download_id     = res_ff.download_id;
   assign rsp_module_id       = res_ff.module_id;
   assign rsp_module_version  = res_ff.module_version;
   assign rsp_block_number    = res_ff.block_number;

endmodule

/* tb/sv/ddb_section_checker.sv */
module ddb_section_checker #(
   parameter int MAX_BYTES = ddbsp_pkg::MAX_SECTION_BYTES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_section_byte,
   input  logic                  req_last_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic                  rsp_kind,
   input  logic [7:0]            rsp_data_byte,
   input  logic [2:0]            rsp_status,
   input  logic [15:0]           rsp_tid_ext,
   input  logic [4:0]            rsp_sect_version,
   input  logic [7:0]            rsp_sect_index,
   input  logic [7:0]            rsp_last_sect_index,
   input  logic [15:0]           rsp_message_id,
   input  logic [31:0]           rsp_download_id,
   input  logic [15:0]           rsp_module_id,
   input  logic [7:0]            rsp_module_version,
   input  logic [15:0]           rsp_block_number,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [ddbsp_pkg::MIN_SIZE_W-1:0] csr_min_section_size,
   output int                    errors,
   output int                    pending,
   output int                    data_checked,
   output int                    summaries_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [ddbsp_pkg::MIN_SIZE_W-1:0] min_size;
   int                    byte_cnt;
   logic                  too_long;
   logic [31:0]           crc_acc;
   logic [11:0]           sec_len;
   logic [15:0]           tid_ext;
   logic [4:0]            ver;
   logic [7:0]            sec_num;
   logic [7:0]            last_sec;
   logic [15:0]           msg_id;
   logic [31:0]           dl_id;
   logic [7:0]            adapt_len;
   logic [15:0]           msg_len;
   logic [15:0]           mod_id;
   logic [7:0]            mod_ver;
   logic [15:0]           blk_num;

   ddbsp_pkg::result_type expected_q[$];
   int         err_n;
   int         n_data;
   int         n_sum;

   function automatic logic [31:0] crc_shift(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         r = r[31] ? ((r << 1) ^ ddbsp_pkg::CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   function automatic void clear_section();
      byte_cnt  = 0;
      too_long  = 1'b0;
      crc_acc   = ddbsp_pkg::CRC_INIT;
      sec_len   = '0;
      tid_ext   = '0;
      ver       = '0;
      sec_num   = '0;
      last_sec  = '0;
      msg_id    = '0;
      dl_id     = '0;
      adapt_len = '0;
      msg_len   = '0;
      mod_id    = '0;
      mod_ver   = '0;
      blk_num   = '0;
   endfunction

   function automatic void capture_byte(input int pos, input logic [7:0] b);
      int rel;
      case (pos)
         1: sec_len = {b[3:0], 8'h00};
         2: sec_len = {sec_len[11:8], b};
         3, 4: tid_ext = {tid_ext[7:0], b};
         5: ver = b[5:1];
         6: sec_num = b;
         7: last_sec = b;
         10, 11: msg_id = {msg_id[7:0], b};
         12, 13, 14, 15: dl_id = {dl_id[23:0], b};
         17: adapt_len = b;
         18, 19: msg_len = {msg_len[7:0], b};
         default: ;
      endcase
      if (pos >= 20 + int'(adapt_len)) begin
         rel = pos - 20 - int'(adapt_len);
         if (rel <= 1) mod_id = {mod_id[7:0], b};
         else if (rel == 2) mod_ver = b;
         else if (rel == 4 || rel == 5) blk_num = {blk_num[7:0], b};
      end
   endfunction

   function automatic bit in_payload(input int pos);
      if (msg_id != ddbsp_pkg::DDB_MESSAGE_ID) return 1'b0;
      if (int'(msg_len) <= int'(adapt_len) + 6) return 1'b0;
      return pos >= 26 + int'(adapt_len) && pos < 20 + int'(msg_len);
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic lst);
      int         pos;
      bit         counted;
      int         size;
      ddbsp_pkg::result_type r;
      pos     = byte_cnt;
      counted = byte_cnt < MAX_BYTES;
      crc_acc = crc_shift(crc_acc, b);
      if (counted) begin
         byte_cnt++;
         capture_byte(pos, b);
      end else begin
         too_long = 1'b1;
      end
      r = '0;
      if (!lst) begin
         if (counted && in_payload(pos)) begin
            r.kind      = ddbsp_pkg::KIND_DATA;
            r.data_byte = b;
            expected_q.push_back(r);
         end
         return;
      end
      size   = byte_cnt;
      r.kind = ddbsp_pkg::KIND_SUMMARY;
      if (too_long || size < int'(min_size) || size < 4) begin
         r.status = ddbsp_pkg::ST_SIZE;
      end else if (crc_acc != 32'h0) begin
         r.status = ddbsp_pkg::ST_CRC;
      end else if (int'(sec_len) + 3 != size) begin
         r.status = ddbsp_pkg::ST_LENGTH;
      end else begin
         r.status          = ddbsp_pkg::ST_OK;
         r.tid_ext         = tid_ext;
         r.sect_version    = ver;
         r.sect_index      = sec_num;
         r.last_sect_index = last_sec;
         if (size > 12) begin
            r.message_id  = msg_id;
            r.download_id = dl_id;
            if (msg_len > 16'(adapt_len)) begin
               if (msg_id == ddbsp_pkg::DDB_MESSAGE_ID) begin
                  r.module_id      = mod_id;
                  r.module_version = mod_ver;
                  r.block_number   = blk_num;
               end else begin
                  r.status = ddbsp_pkg::ST_NOT_DDB;
               end
            end
         end
      end
      expected_q.push_back(r);
      clear_section();
   endtask

   task automatic report(input string msg);
      if (err_n < 40) $display("[%0t] mismatch: %s", $realtime, msg);
      err_n++;
   endtask

   task automatic cmp(input string name, input logic [31:0] got, input logic [31:0] want);
      if (got !== want)
         report($sformatf("result %0d %s: got %0h expected %0h",
                          n_data + n_sum, name, got, want));
   endtask

   task automatic check_result();
      ddbsp_pkg::result_type want;
      if (expected_q.size() == 0) begin
         report($sformatf("result with nothing expected, kind %0d byte %0h status %0d",
                          rsp_kind, rsp_data_byte, rsp_status));
         return;
      end
      want = expected_q.pop_front();
      cmp("kind", 32'(rsp_kind), 32'(want.kind));
      cmp("data_byte", 32'(rsp_data_byte), 32'(want.data_byte));
      cmp("status", 32'(rsp_status), 32'(want.status));
      cmp("tid_ext", 32'(rsp_tid_ext), 32'(want.tid_ext));
      cmp("sect_version", 32'(rsp_sect_version), 32'(want.sect_version));
      cmp("sect_index", 32'(rsp_sect_index), 32'(want.sect_index));
      cmp("last_sect_index", 32'(rsp_last_sect_index), 32'(want.last_sect_index));
      cmp("message_id", 32'(rsp_message_id), 32'(want.message_id));
      cmp("download_id", rsp_download_id, want.download_id);
      cmp("module_id", 32'(rsp_module_id), 32'(want.module_id));
      cmp("module_version", 32'(rsp_module_version), 32'(want.module_version));
      cmp("block_number", 32'(rsp_block_number), 32'(want.block_number));
      if (want.kind == ddbsp_pkg::KIND_SUMMARY) n_sum++;
      else n_data++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         min_size = ddbsp_pkg::MIN_SIZE_RESET;
         clear_section();
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) min_size = csr_min_section_size;
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) predict_byte(req_section_byte, req_last_byte);
      end
      pending           <= expected_q.size();
      errors            <= err_n;
      data_checked      <= n_data;
      summaries_checked <= n_sum;
   end

endmodule

/* tb/sv/dsmcc_ddb_section_parser_test.sv */
module dsmcc_ddb_section_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RANDOM_BYTES   = 400;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          WATCHDOG_LIMIT = 5000;
   localparam int          SETTLE_CYCLES  = 6;
   localparam logic [7:0]  DSMCC_PROTOCOL = 8'h11;
   localparam logic [7:0]  DSMCC_DL_TYPE  = 8'h03;
   localparam logic [15:0] DII_MESSAGE_ID = 16'h1002;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_section_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_tid_ext;
   logic [4:0]  rsp_sect_version;
   logic [7:0]  rsp_sect_index;
   logic [7:0]  rsp_last_sect_index;
   logic [15:0] rsp_message_id;
   logic [31:0] rsp_download_id;
   logic [15:0] rsp_module_id;
   logic [7:0]  rsp_module_version;
   logic [15:0] rsp_block_number;
   logic        csr_valid;
   logic        csr_ready;
   logic [ddbsp_pkg::MIN_SIZE_W-1:0] csr_min_section_size;

   int errors;
   int pending;
   int data_checked;
   int summaries_checked;

   logic [7:0] sect_q[$];
   bit         idle_mode;
   bit         rsp_hold_req;
   int         bytes_sent;
   int         sections_sent;

   dsmcc_ddb_section_parser DUT (.*);

   ddb_section_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stalls plus one long hold-off on request
   initial begin
      int stall_left;
      int r;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (!idle_mode || r < 70) begin
               rsp_stall <= 1'b0;
            end else begin
               rsp_stall <= 1'b1;
               stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
         end
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {b, 24'h0};
      for (int i = 0; i < 8; i++) begin
         r = r[31] ? ((r << 1) ^ ddbsp_pkg::CRC_POLY) : (r << 1);
      end
      return r;
   endfunction

   function automatic logic [7:0] rnd_byte(input int fill);
      return (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
   endfunction

   task automatic seal_section(input bit corrupt);
      logic [31:0] c;
      c = ddbsp_pkg::CRC_INIT;
      foreach (sect_q[i]) c = crc_feed(c, sect_q[i]);
      sect_q.push_back(c[31:24]);
      sect_q.push_back(c[23:16]);
      sect_q.push_back(c[15:8]);
      sect_q.push_back(c[7:0]);
      if (corrupt) sect_q[sect_q.size() - 1] ^= 8'($urandom_range(1, 255));
   endtask

   // download data block section, length and crc patched to match unless skewed
   task automatic build_ddb(input int adapt_n, input int data_n, input logic [15:0] msg_kind,
                            input int msg_skew, input int len_skew, input bit bad_crc,
                            input int fill);
      logic [15:0] mlen;
      logic [11:0] slen;
      logic [7:0]  b;
      sect_q.delete();
      mlen = 16'(adapt_n + 6 + data_n + msg_skew);
      repeat (8) sect_q.push_back(rnd_byte(fill));
      sect_q.push_back(DSMCC_PROTOCOL);
      sect_q.push_back(DSMCC_DL_TYPE);
      sect_q.push_back(msg_kind[15:8]);
      sect_q.push_back(msg_kind[7:0]);
      repeat (4) sect_q.push_back(rnd_byte(fill));
      sect_q.push_back(8'hFF);
      sect_q.push_back(8'(adapt_n));
      sect_q.push_back(mlen[15:8]);
      sect_q.push_back(mlen[7:0]);
      repeat (adapt_n + 6 + data_n) sect_q.push_back(rnd_byte(fill));
      slen = 12'(sect_q.size() + 1 + len_skew);
      b = sect_q[1];
      sect_q[1] = {b[7:4], slen[11:8]};
      sect_q[2] = slen[7:0];
      seal_section(bad_crc);
   endtask

   task automatic build_short(input int n);
      logic [11:0] slen;
      logic [7:0]  b;
      sect_q.delete();
      repeat (n - 4) sect_q.push_back(rnd_byte(-1));
      if (n >= 7) begin
         slen = 12'(n - 3);
         b = sect_q[1];
         sect_q[1] = {b[7:4], slen[11:8]};
         sect_q[2] = slen[7:0];
      end
      seal_section(1'b0);
   endtask

   task automatic build_noise(input int n);
      sect_q.delete();
      repeat (n) sect_q.push_back(rnd_byte(-1));
   endtask

   function automatic int pick_gap();
      int r;
      if (!idle_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic lst);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_section_byte <= b;
      req_last_byte    <= lst;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_section();
      foreach (sect_q[i]) send_byte(sect_q[i], i == sect_q.size() - 1);
      sections_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_min_size(input logic [ddbsp_pkg::MIN_SIZE_W-1:0] v);
      drain();
      csr_valid            <= 1'b1;
      csr_min_section_size <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_section();
      int r;
      int a;
      int d;
      r = $urandom_range(0, 99);
      a = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3);
      d = $urandom_range(0, 12);
      if (r < 55)
         build_ddb(a, d, ddbsp_pkg::DDB_MESSAGE_ID, 0, 0, 1'b0, -1);
      else if (r < 61)
         build_ddb(a, d, ddbsp_pkg::DDB_MESSAGE_ID, int'($urandom_range(0, 16)) - 8, 0,
                   1'b0, -1);
      else if (r < 67)
         build_ddb(a, d, ddbsp_pkg::DDB_MESSAGE_ID, 0, int'($urandom_range(0, 6)) - 3,
                   1'b0, -1);
      else if (r < 72)
         build_ddb(a, d, ddbsp_pkg::DDB_MESSAGE_ID, 0, 0, 1'b1, -1);
      else if (r < 77)
         build_ddb(a, d, 16'($urandom_range(0, 65535)), 0, 0, 1'b0, -1);
      else if (r < 87)
         build_short($urandom_range(4, 28));
      else
         build_noise($urandom_range(1, 40));
      send_section();
   endtask

   initial begin
      int start;
      reset                <= 1'b1;
      req_valid            <= 1'b0;
      req_section_byte     <= '0;
      req_last_byte        <= 1'b0;
      csr_valid            <= 1'b0;
      csr_min_section_size <= '0;
      idle_mode    = 1'b0;
      rsp_hold_req = 1'b0;
      bytes_sent    = 0;
      sections_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed sections at the reset minimum size
      build_ddb(0, 2, ddbsp_pkg::DDB_MESSAGE_ID, 0, 0, 1'b0, 0);
      send_section();
      build_ddb(0, 2, ddbsp_pkg::DDB_MESSAGE_ID, 0, 0, 1'b0, 255);
      send_section();
      build_ddb(3, 4, ddbsp_pkg::DDB_MESSAGE_ID, 0, 0, 1'b0, -1);
      send_section();
      // message length not past adaptation: no module fields
      build_ddb(2, 0, ddbsp_pkg::DDB_MESSAGE_ID, -6, 0, 1'b0, -1);
      send_section();
      build_ddb(0, 0, ddbsp_pkg::DDB_MESSAGE_ID, 0, 0, 1'b0, -1);
      send_section();
      build_ddb(1, 3, DII_MESSAGE_ID, 0, 0, 1'b0, -1);
      send_section();
      build_ddb(0, 3, ddbsp_pkg::DDB_MESSAGE_ID, 0, 0, 1'b1, -1);
      send_section();
      build_ddb(0, 3, ddbsp_pkg::DDB_MESSAGE_ID, 0, 1, 1'b0, -1);
      send_section();
      // payload region runs over the crc and past the end
      build_ddb(0, 2, ddbsp_pkg::DDB_MESSAGE_ID, 9, 0, 1'b0, -1);
      send_section();
      build_short(12);
      send_section();
      build_short(16);
      send_section();
      build_short(10);
      send_section();
      build_short(4);
      send_section();
      build_noise(3);
      send_section();
      build_noise(1);
      send_section();

      write_min_size('0);
      build_short(4);
      send_section();
      build_short(5);
      send_section();
      build_noise(2);
      send_section();
      build_short(9);
      send_section();

      write_min_size(13'd4095);
      build_short(20);
      send_section();

      write_min_size(13'd4096);
      build_short(28);
      send_section();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_min_size(ddbsp_pkg::MIN_SIZE_RESET);
            1: write_min_size(ddbsp_pkg::MIN_SIZE_W'($urandom_range(0, 30)));
            2: write_min_size(ddbsp_pkg::MIN_SIZE_RESET);
            default: write_min_size(ddbsp_pkg::MIN_SIZE_W'($urandom_range(13, 40)));
         endcase
         idle_mode = (ph != 0);
         start = bytes_sent;
         if (ph == 2) rsp_hold_req = 1'b1;
         while (bytes_sent - start < RANDOM_BYTES / 4) begin
            random_section();
            if ($urandom_range(0, 19) == 0) drain();
         end
      end

      drain();
      $display("covered %0d sections in %0d bytes, checked %0d payload bytes and %0d summaries",
               sections_sent, bytes_sent, data_checked, summaries_checked);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
sv/ddbsp_pkg.sv
sv/ddbsp_in_reg.sv
sv/ddbsp_core.sv
sv/dsmcc_ddb_section_parser.sv
tb/sv/ddb_section_checker.sv
tb/sv/dsmcc_ddb_section_parser_test.sv
